// File: sv/cvs_pkg.sv
// Package for the scaled valid-mode 2D convolution core: payload types, codes, sizes.
package cvs_pkg;

  localparam int DATA_BITS = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_KERNEL = 8;
  localparam int DEF_MAX_WIDTH  = 256;

  typedef enum logic {
    CMD_COEF  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_SCALE        = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LREAD,
    ST_LWAIT,
    ST_SHIFT,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    cmd_e                        command;
    logic [5:0]                  coef_index;
    logic signed [DATA_BITS-1:0] value;
  } conv_in_t;

  typedef struct packed {
    logic signed [31:0] conv_value;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic               last;
  } conv_out_t;

endpackage

// File: sv/conv2d_valid_scaled_core.sv
// Top level of the scaled valid-mode 2D convolution core.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (coef load or pixel)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (scaled window sum)
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An accepted pixel gets K-1 line reads and a wait (K > 1), then a window shift.
// A pixel that completes a window adds K*K multiply-accumulate steps through one multiplier
// fed by the coefficient memory, then the drain, scale and output states.
// The line store has a single port, so the K-1 column reads come one per cycle.
// Reset clears position, window registers and control and sets config to its defaults; memories are not cleared.
// A full output register holds the sequencer in its output state; no new items are taken while it waits.
module conv2d_valid_scaled_core #(
  parameter int MAX_KERNEL = cvs_pkg::DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = cvs_pkg::DEF_MAX_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  cvs_pkg::conv_in_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output cvs_pkg::conv_out_t                     out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [cvs_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [cvs_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import cvs_pkg::*;

  localparam int LR     = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int LDEPTH = LR * MAX_WIDTH;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int KIW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int SW     = (LR > 1) ? $clog2(LR) : 1;
  localparam int PRW    = 2 * DATA_BITS;
  localparam int ACC_W  = PRW + 2 * KIW + 1;
  localparam int PW     = ACC_W + CFG_DATA_W;

  // configuration
  logic [3:0]                   ksize_q;
  logic [8:0]                   iw_q, ih_q;
  logic signed [CFG_DATA_W-1:0] scale_q;

  // memories
  logic signed [DATA_BITS-1:0] line_mem [LDEPTH];
  logic signed [DATA_BITS-1:0] coef_mem [CDEPTH];
  logic signed [DATA_BITS-1:0] line_rd_q, coef_rd_q;

  // position and pixel context
  logic [7:0]    row_q, col_q;
  logic [SW-1:0] slot_q;
  logic [7:0]    pr_q, pc_q;
  logic [SW-1:0] ps_q;
  logic signed [DATA_BITS-1:0] pv_q;

  logic signed [DATA_BITS-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
  logic signed [DATA_BITS-1:0] colv_q [MAX_KERNEL];

  state_e state_q, state_d;
  logic [KIW-1:0] rd_kr_q;
  logic           rd_pend_q;
  logic [KIW-1:0] rd_idx_q;
  logic [KIW-1:0] mkr_q, mkc_q;
  logic [CAW-1:0] cidx_q;
  logic           mv1_q, mv2_q;
  logic signed [DATA_BITS-1:0] wsel_q;
  logic signed [PRW-1:0]       prod_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [PW-1:0]        sc_q;

  logic      out_valid_q;
  conv_out_t out_q;

  // clamped sizes
  logic [KW-1:0] k;
  logic [8:0]    w, h;
  always_comb begin
    if (ksize_q == 4'd0) k = KW'(1);
    else if ({1'b0, ksize_q} > 5'(MAX_KERNEL)) k = KW'(MAX_KERNEL);
    else k = KW'(ksize_q);
    if (iw_q == 9'd0) w = 9'd1;
    else if ({23'd0, iw_q} > MAX_WIDTH) w = 9'(MAX_WIDTH);
    else w = iw_q;
    if (ih_q == 9'd0) h = 9'd1;
    else if (ih_q > 9'd256) h = 9'd256;
    else h = ih_q;
  end

  logic in_acc, acc_pix, acc_coef, out_slot_free;
  assign in_acc        = in_valid_i && in_ready_o;
  assign acc_pix       = in_acc && (in_data_i.command == CMD_PIXEL);
  assign acc_coef      = in_acc && (in_data_i.command == CMD_COEF);
  assign out_slot_free = !out_valid_q || out_ready_i;
  assign cfg_ready_o   = 1'b1;

  // position of the arriving pixel after wrapping a stale position
  logic [7:0]    a_row, a_col;
  logic [SW-1:0] a_slot;
  logic [8:0]    a_r9;
  always_comb begin
    a_col  = col_q;
    a_r9   = {1'b0, row_q};
    a_slot = slot_q;
    if ({1'b0, col_q} >= w) begin
      a_col  = 8'd0;
      a_r9   = a_r9 + 9'd1;
      a_slot = (slot_q == SW'(LR - 1)) ? SW'(0) : slot_q + SW'(1);
    end
    if (a_r9 >= h) begin
      a_r9   = 9'd0;
      a_slot = SW'(0);
    end
    a_row = a_r9[7:0];
  end

  // position after this pixel
  logic [7:0]    n_row, n_col;
  logic [SW-1:0] n_slot;
  logic [8:0]    n_c9, n_r9;
  always_comb begin
    n_c9   = {1'b0, pc_q} + 9'd1;
    n_r9   = {1'b0, pr_q};
    n_slot = ps_q;
    if (n_c9 >= w) begin
      n_c9   = 9'd0;
      n_r9   = n_r9 + 9'd1;
      n_slot = (ps_q == SW'(LR - 1)) ? SW'(0) : ps_q + SW'(1);
      if (n_r9 >= h) begin
        n_r9   = 9'd0;
        n_slot = SW'(0);
      end
    end
    n_row = n_r9[7:0];
    n_col = n_c9[7:0];
  end

  // line address: read address for window row rd_kr_q, else write address for this pixel
  logic [SW-1:0] rd_slot;
  logic [LAW-1:0] line_addr;
  int back, sd;
  always_comb begin
    back = int'(k) - 1 - int'(rd_kr_q);
    sd   = int'(ps_q) - back;
    if (sd < 0) sd = sd + LR;
    rd_slot = (int'(pr_q) >= back) ? SW'(sd) : SW'(0);
    if (state_q == ST_LREAD) line_addr = LAW'(rd_slot) * LAW'(MAX_WIDTH) + LAW'(pc_q);
    else line_addr = LAW'(ps_q) * LAW'(MAX_WIDTH) + LAW'(pc_q);
  end

  logic produce, rd_last, mac_last;
  assign produce  = ({1'b0, pr_q} + 9'd1 >= 9'(k)) && ({1'b0, pc_q} + 9'd1 >= 9'(k));
  assign rd_last  = (int'(rd_kr_q) + 2 >= int'(k));
  assign mac_last = (int'(mkr_q) + 1 == int'(k)) && (int'(mkc_q) + 1 == int'(k));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_pix) state_d = (k > KW'(1)) ? ST_LREAD : ST_SHIFT;
      end
      ST_LREAD: if (rd_last) state_d = ST_LWAIT;
      ST_LWAIT: state_d = ST_SHIFT;
      ST_SHIFT: state_d = produce ? ST_MAC : ST_IDLE;
      ST_MAC:   if (mac_last) state_d = ST_DRAIN;
      ST_DRAIN: if (!mv1_q && !mv2_q) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT:   if (out_slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic line_we, line_re, mac_issue, out_load;
  always_comb begin
    in_ready_o = 1'b0;
    line_we    = 1'b0;
    line_re    = 1'b0;
    mac_issue  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_LREAD: line_re    = 1'b1;
      ST_SHIFT: line_we    = (MAX_KERNEL > 1);
      ST_MAC:   mac_issue  = 1'b1;
      ST_OUT:   out_load   = out_slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_addr] <= pv_q;
    if (line_re) line_rd_q <= line_mem[line_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_coef && ({26'd0, in_data_i.coef_index} < CDEPTH))
      coef_mem[CAW'(in_data_i.coef_index)] <= in_data_i.value;
    if (mac_issue) coef_rd_q <= coef_mem[cidx_q];
  end

  // saturated result
  logic signed [PW-1:0] sh;
  logic signed [31:0]   sat;
  always_comb begin
    sh = sc_q >>> 14;
    if (sh > $signed({{(PW-31){1'b0}}, {31{1'b1}}})) sat = 32'sh7fffffff;
    else if (sh < $signed({{(PW-31){1'b1}}, {31{1'b0}}})) sat = 32'sh80000000;
    else sat = sh[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (acc_pix) begin
      pv_q <= in_data_i.value;
      pr_q <= a_row;
      pc_q <= a_col;
      ps_q <= a_slot;
    end
    if (rd_pend_q) colv_q[rd_idx_q] <= line_rd_q;
    if (mac_issue) wsel_q <= win_q[mkr_q][mkc_q];
    if (mv1_q) prod_q <= coef_rd_q * wsel_q;
    if (state_q == ST_SCALE) sc_q <= PW'(acc_q) * PW'(scale_q);
    if (out_load) begin
      out_q.conv_value <= sat;
      out_q.out_row    <= pr_q + 8'd1 - 8'(k);
      out_q.out_col    <= pc_q + 8'd1 - 8'(k);
      out_q.last       <= ({1'b0, pr_q} + 9'd1 == h) && ({1'b0, pc_q} + 9'd1 == w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q     <= 4'd3;
      iw_q        <= 9'd28;
      ih_q        <= 9'd28;
      scale_q     <= 16'sd16384;
      row_q       <= 8'd0;
      col_q       <= 8'd0;
      slot_q      <= '0;
      state_q     <= ST_IDLE;
      rd_kr_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      mkr_q       <= '0;
      mkc_q       <= '0;
      cidx_q      <= '0;
      mv1_q       <= 1'b0;
      mv2_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int c = 0; c < MAX_KERNEL; c++) win_q[r][c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_KERNEL_SIZE:  ksize_q <= cfg_data_i[3:0];
          REG_IMAGE_WIDTH:  iw_q    <= cfg_data_i[8:0];
          REG_IMAGE_HEIGHT: ih_q    <= cfg_data_i[8:0];
          REG_SCALE:        scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc_pix) rd_kr_q <= '0;
      else if (line_re) rd_kr_q <= rd_kr_q + KIW'(1);
      rd_pend_q <= line_re;
      rd_idx_q  <= rd_kr_q;
      if (line_we || (state_q == ST_SHIFT)) begin
        // shift the window left and insert the new column
        for (int r = 0; r < MAX_KERNEL; r++) begin
          for (int c = 0; c < MAX_KERNEL; c++) begin
            if (r < int'(k)) begin
              if (c + 1 < int'(k)) win_q[r][c] <= win_q[r][c+1];
              else if (c + 1 == int'(k)) win_q[r][c] <= (r + 1 == int'(k)) ? pv_q : colv_q[r];
            end
          end
        end
        row_q  <= n_row;
        col_q  <= n_col;
        slot_q <= n_slot;
        mkr_q  <= '0;
        mkc_q  <= '0;
        cidx_q <= '0;
        acc_q  <= '0;
      end
      if (mac_issue) begin
        cidx_q <= cidx_q + CAW'(1);
        if (int'(mkc_q) + 1 == int'(k)) begin
          mkc_q <= '0;
          mkr_q <= mkr_q + KIW'(1);
        end else begin
          mkc_q <= mkc_q + KIW'(1);
        end
      end
      mv1_q <= mac_issue;
      mv2_q <= mv1_q;
      if (mv2_q) acc_q <= acc_q + ACC_W'(prod_q);
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/tb_conv2d_valid_scaled_core.sv
// Testbench for the scaled valid-mode 2D convolution core: random streams against a predictor.
module tb_conv2d_valid_scaled_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cvs_pkg::*;

  localparam int LINE_ROWS   = DEF_MAX_KERNEL - 1;
  localparam int SETTLE_CYC  = 120;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 1550;

  class conv_predictor;
    int unsigned          ksz, wid, hgt;
    longint               scl;
    logic signed [15:0]   coef[64];
    logic signed [15:0]   line_buf[LINE_ROWS][DEF_MAX_WIDTH];
    logic signed [15:0]   win[DEF_MAX_KERNEL][DEF_MAX_KERNEL];
    int unsigned          prow, pcol;
    conv_out_t            due[$];
    int                   errors;

    function new();
      ksz = 3; wid = 28; hgt = 28; scl = 16384;
      prow = 0; pcol = 0; errors = 0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] d);
      case (idx)
        REG_KERNEL_SIZE:  ksz = d[3:0];
        REG_IMAGE_WIDTH:  wid = d[8:0];
        REG_IMAGE_HEIGHT: hgt = d[8:0];
        REG_SCALE:        scl = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function void note_input(conv_in_t x);
      int unsigned k, w, h, r, c, kr, kc, back, slot;
      longint      acc, prod;
      conv_out_t   o;
      if (x.command == CMD_COEF) begin
        coef[x.coef_index] = x.value;
        return;
      end
      k = fit(ksz, DEF_MAX_KERNEL);
      w = fit(wid, DEF_MAX_WIDTH);
      h = fit(hgt, 256);
      r = prow;
      c = pcol;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      // shift the window left, bring in the new column from the line rows
      for (kr = 0; kr < k; kr++) begin
        for (kc = 0; kc + 1 < k; kc++) win[kr][kc] = win[kr][kc+1];
        if (kr + 1 == k) begin
          win[kr][k-1] = x.value;
        end else begin
          back = k - 1 - kr;
          slot = (r >= back) ? (r - back) % LINE_ROWS : 0;
          win[kr][k-1] = line_buf[slot][c];
        end
      end
      line_buf[r % LINE_ROWS][c] = x.value;
      if (r + 1 >= k && c + 1 >= k) begin
        acc = 0;
        for (kr = 0; kr < k; kr++)
          for (kc = 0; kc < k; kc++)
            acc += longint'(coef[kr*k+kc]) * longint'(win[kr][kc]);
        prod = (acc * scl) >>> 14;
        if (prod > 64'sd2147483647) prod = 64'sd2147483647;
        if (prod < -64'sd2147483648) prod = -64'sd2147483648;
        o.conv_value = prod[31:0];
        o.out_row    = 8'(r + 1 - k);
        o.out_col    = 8'(c + 1 - k);
        o.last       = (r + 1 == h && c + 1 == w);
        due.push_back(o);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      prow = r;
      pcol = c;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check(conv_out_t got);
      conv_out_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = due.pop_front();
      if (got.conv_value !== want.conv_value)
        report($sformatf("conv_value %0d, want %0d", got.conv_value, want.conv_value));
      if (got.out_row !== want.out_row)
        report($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
        report($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  conv_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  conv_out_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  conv_predictor sb = new();
  bit            calm;
  int            items_sent;
  int            quiet_cycles;

  conv2d_valid_scaled_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task send(conv_in_t x);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(x);
    items_sent++;
  endtask

  task load_coef(logic [5:0] idx, logic [15:0] v);
    conv_in_t x;
    x.command    = CMD_COEF;
    x.coef_index = idx;
    x.value      = v;
    send(x);
  endtask

  task send_pixel(logic [15:0] v);
    conv_in_t x;
    x.command    = CMD_PIXEL;
    x.coef_index = 6'($urandom);
    x.value      = v;
    send(x);
  endtask

  // drop valid and wait until the core has drained every pending result
  task settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task write_reg(reg_idx_e idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    cfg_valid_i <= 1'b0;
  endtask

  task run_phase(logic [15:0] k, logic [15:0] w, logic [15:0] h, logic [15:0] s,
                 int images, bit mid_scale, bit fixed_pix, logic [15:0] pix);
    int total;
    settle();
    calm = ($urandom_range(0, 3) == 0);
    write_reg(REG_KERNEL_SIZE, k);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SCALE, s);
    total = images * sb.fit(w[8:0], DEF_MAX_WIDTH) * sb.fit(h[8:0], 256);
    for (int i = 0; i < total; i++) begin
      if (mid_scale && i == total / 2) begin
        settle();
        write_reg(REG_SCALE, pick_value());
      end
      if (!fixed_pix && $urandom_range(0, 11) == 0) load_coef(6'($urandom), pick_value());
      send_pixel(fixed_pix ? pix : pick_value());
    end
  endtask

  // result side: random stalls, compare every transfer
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k, w, h;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= REG_KERNEL_SIZE;
    cfg_data_i   <= '0;
    items_sent   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturate both ways with an all-extreme 2x2 window
    for (int i = 0; i < 4; i++) load_coef(6'(i), 16'h8000);
    run_phase(16'd2, 16'd2, 16'd2, 16'h7fff, 1, 1'b0, 1'b1, 16'h8000);
    run_phase(16'd2, 16'd2, 16'd2, 16'h8000, 1, 1'b0, 1'b1, 16'h8000);
    for (int i = 0; i < 64; i++) load_coef(6'(i), pick_value());
    // zero sizes act as one, oversized kernel, oversized width and height
    run_phase(16'd0, 16'd0, 16'd0, 16'h4000, 1, 1'b0, 1'b0, '0);
    run_phase(16'd15, 16'd3, 16'd3, 16'h4000, 1, 1'b0, 1'b0, '0);
    run_phase(16'd9, 16'd9, 16'd8, 16'h2000, 1, 1'b0, 1'b0, '0);
    run_phase(16'd1, 16'd511, 16'd1, 16'h7fff, 1, 1'b0, 1'b0, '0);
    run_phase(16'd1, 16'd1, 16'd300, 16'hc000, 1, 1'b0, 1'b0, '0);
    run_phase(16'd8, 16'd12, 16'd9, 16'h0001, 1, 1'b0, 1'b0, '0);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       k = $urandom_range(5, 8);
        1:       k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
        default: k = $urandom_range(1, 4);
      endcase
      if ($urandom_range(0, 6) == 0) begin
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 6);
      end else begin
        w = sb.fit(k, DEF_MAX_KERNEL) + $urandom_range(0, 6);
        h = sb.fit(k, DEF_MAX_KERNEL) + $urandom_range(0, 5);
      end
      run_phase(16'(k), 16'(w), 16'(h), pick_value(), $urandom_range(1, 2),
                ($urandom_range(0, 4) == 0), 1'b0, '0);
    end

    settle();
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
